// ===== hdl/sepr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sepr_pkg
// Types, widths and helpers shared by the segment endpoint proximity test.
// ----------------------------------------------------------------------------
package sepr_pkg;

    localparam int COORD_BITS     = 16;
    localparam int PROJ_FRAC_BITS = 16;

    localparam int REG_W  = 34;                 // config register width
    localparam int DIST_W = 33;                 // reported squared distance

    localparam int DIFF_W = COORD_BITS + 1;     // coordinate difference
    localparam int LEN_W  = 2 * DIFF_W;         // squared length
    localparam int DOT_W  = LEN_W + 1;          // signed dot product
    localparam int REM_W  = LEN_W + 1;          // divider remainder
    localparam int Q_W    = PROJ_FRAC_BITS + 1; // projection parameter t
    localparam int PROD_W = Q_W + 1 + DIFF_W;   // t * d
    localparam int OFS_W  = DIFF_W + 2;         // offset from projected point
    localparam int SUM_W  = 2 * OFS_W + 1;      // sum of two squares

    localparam int NUM_LANES = 4;

    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [Q_W-1:0] PROJ_ONE = {1'b1, {PROJ_FRAC_BITS{1'b0}}};

    // configuration register indexes
    localparam logic CFG_MAX_DIST_SQ   = 1'b0;
    localparam logic CFG_MIN_LENGTH_SQ = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_start_w;
        logic signed [COORD_BITS-1:0] a_start_t;
        logic signed [COORD_BITS-1:0] a_end_w;
        logic signed [COORD_BITS-1:0] a_end_t;
        logic signed [COORD_BITS-1:0] b_start_w;
        logic signed [COORD_BITS-1:0] b_start_t;
        logic signed [COORD_BITS-1:0] b_end_w;
        logic signed [COORD_BITS-1:0] b_end_t;
    } t_in;

    typedef struct packed {
        logic              compatible;
        logic [DIST_W-1:0] min_dist_sq;
        logic              short_segment_seen;
    } t_out;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] w;
        logic signed [COORD_BITS-1:0] t;
    } t_pt;

    // what one lane found for one point/segment test
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] dsq;
        logic              short_seg;
    } t_lane_res;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [SUM_W-1:0] s);
        logic [DIST_W-1:0] r;
        r = (|s[SUM_W-1:DIST_W]) ? {DIST_W{1'b1}} : s[DIST_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sepr_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sepr_lane
// Squared distance of one point to one segment: difference and product
// stages, a restoring divider one quotient bit per stage, then projection.
// ----------------------------------------------------------------------------
module sepr_lane (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire sepr_pkg::t_pt               i_p,
    input  wire sepr_pkg::t_pt               i_s,
    input  wire sepr_pkg::t_pt               i_e,
    input  wire logic [sepr_pkg::REG_W-1:0]  i_min_len,
    output sepr_pkg::t_lane_res              o_res
);
    import sepr_pkg::*;

    typedef struct packed {
        logic                     valid;
        logic                     short_seg;
        logic                     trivial;   // result is |P-S|^2
        logic                     far;       // result is |P-E|^2
        logic signed [DIFF_W-1:0] rw;
        logic signed [DIFF_W-1:0] rt;
        logic signed [DIFF_W-1:0] dw;
        logic signed [DIFF_W-1:0] dt;
        logic [DIST_W-1:0]        dist_s;
        logic [DIST_W-1:0]        dist_e;
    } t_carry;

    // stage 0: differences
    logic                     r0_valid;
    logic signed [DIFF_W-1:0] r0_dw, r0_dt, r0_rw, r0_rt, r0_ew, r0_et;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= i_valid;
        end
        r0_dw <= DIFF_W'(i_e.w) - DIFF_W'(i_s.w);
        r0_dt <= DIFF_W'(i_e.t) - DIFF_W'(i_s.t);
        r0_rw <= DIFF_W'(i_p.w) - DIFF_W'(i_s.w);
        r0_rt <= DIFF_W'(i_p.t) - DIFF_W'(i_s.t);
        r0_ew <= DIFF_W'(i_p.w) - DIFF_W'(i_e.w);
        r0_et <= DIFF_W'(i_p.t) - DIFF_W'(i_e.t);
    end

    // stage 1: products
    logic                     r1_valid;
    logic signed [LEN_W-1:0]  r1_dw2, r1_dt2, r1_pdw, r1_pdt;
    logic signed [LEN_W-1:0]  r1_sqsw, r1_sqst, r1_sqew, r1_sqet;
    logic signed [DIFF_W-1:0] r1_dw, r1_dt, r1_rw, r1_rt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= r0_valid;
        end
        r1_dw2  <= r0_dw * r0_dw;
        r1_dt2  <= r0_dt * r0_dt;
        r1_pdw  <= r0_rw * r0_dw;
        r1_pdt  <= r0_rt * r0_dt;
        r1_sqsw <= r0_rw * r0_rw;
        r1_sqst <= r0_rt * r0_rt;
        r1_sqew <= r0_ew * r0_ew;
        r1_sqet <= r0_et * r0_et;
        r1_dw   <= r0_dw;
        r1_dt   <= r0_dt;
        r1_rw   <= r0_rw;
        r1_rt   <= r0_rt;
    end

    // stage 2: length, dot product, early decisions
    logic [LEN_W-1:0]        w_len2;
    logic signed [DOT_W-1:0] w_dot;
    logic [SUM_W-1:0]        w_sum_s, w_sum_e;
    logic                    w_short;

    assign w_len2  = $unsigned(r1_dw2) + $unsigned(r1_dt2);
    assign w_dot   = r1_pdw + r1_pdt;
    assign w_sum_s = {{(SUM_W-LEN_W){1'b0}}, $unsigned(r1_sqsw)}
                   + {{(SUM_W-LEN_W){1'b0}}, $unsigned(r1_sqst)};
    assign w_sum_e = {{(SUM_W-LEN_W){1'b0}}, $unsigned(r1_sqew)}
                   + {{(SUM_W-LEN_W){1'b0}}, $unsigned(r1_sqet)};
    assign w_short = w_len2 < i_min_len;

    // divider pipeline: index 0 is loaded here, index k+1 after quotient bit k
    logic [REM_W-1:0] r_rem [Q_W+1];
    logic [Q_W-1:0]   r_q   [Q_W+1];
    logic [LEN_W-1:0] r_len [Q_W+1];
    t_carry           r_c   [Q_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c[0].valid <= 1'b0;
        end else begin
            r_c[0].valid <= r1_valid;
        end
        r_c[0].short_seg <= w_short;
        r_c[0].trivial   <= w_short || (w_len2 == '0) || w_dot[DOT_W-1];
        // dot >= 2*len2 puts t beyond the end point for sure
        r_c[0].far       <= $unsigned(w_dot) >= {w_len2, 1'b0};
        r_c[0].rw        <= r1_rw;
        r_c[0].rt        <= r1_rt;
        r_c[0].dw        <= r1_dw;
        r_c[0].dt        <= r1_dt;
        r_c[0].dist_s    <= sat_dist(w_sum_s);
        r_c[0].dist_e    <= sat_dist(w_sum_e);
        r_rem[0]         <= $unsigned(w_dot);
        r_q[0]           <= '0;
        r_len[0]         <= w_len2;
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        logic             w_ge;
        logic [REM_W-1:0] w_rn;

        assign w_ge = r_rem[k] >= {1'b0, r_len[k]};
        assign w_rn = w_ge ? (r_rem[k] - {1'b0, r_len[k]}) : r_rem[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c[k+1].valid <= 1'b0;
            end else begin
                r_c[k+1] <= r_c[k];
            end
            r_rem[k+1] <= {w_rn[REM_W-2:0], 1'b0};
            r_q[k+1]   <= {r_q[k][Q_W-2:0], w_ge};
            r_len[k+1] <= r_len[k];
        end
    end

    // P1: t * d
    t_carry                   w_c4;
    t_carry                   r4_c;
    logic signed [PROD_W-1:0] r4_pw, r4_pt;

    always_comb begin
        w_c4     = r_c[Q_W];
        w_c4.far = r_c[Q_W].far || (r_q[Q_W] > PROJ_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_c.valid <= 1'b0;
        end else begin
            r4_c <= w_c4;
        end
        r4_pw <= $signed({1'b0, r_q[Q_W]}) * r_c[Q_W].dw;
        r4_pt <= $signed({1'b0, r_q[Q_W]}) * r_c[Q_W].dt;
    end

    // P2: offset from the projected point (arithmetic shift is a floor)
    logic signed [PROD_W-1:0] w_shw, w_sht;
    logic signed [OFS_W-1:0]  w_offw, w_offt;
    t_carry                   r5_c;
    logic signed [OFS_W-1:0]  r5_ow, r5_ot;

    assign w_shw  = r4_pw >>> PROJ_FRAC_BITS;
    assign w_sht  = r4_pt >>> PROJ_FRAC_BITS;
    assign w_offw = w_shw[OFS_W-1:0];
    assign w_offt = w_sht[OFS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_c.valid <= 1'b0;
        end else begin
            r5_c <= r4_c;
        end
        r5_ow <= r4_c.rw - w_offw;
        r5_ot <= r4_c.rt - w_offt;
    end

    // P3: squares
    t_carry                   r6_c;
    logic signed [2*OFS_W-1:0] r6_sqw, r6_sqt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_c.valid <= 1'b0;
        end else begin
            r6_c <= r5_c;
        end
        r6_sqw <= r5_ow * r5_ow;
        r6_sqt <= r5_ot * r5_ot;
    end

    // P4: pick the case
    logic [SUM_W-1:0] w_sum_p;
    t_lane_res        r7_res;

    assign w_sum_p = {1'b0, $unsigned(r6_sqw)} + {1'b0, $unsigned(r6_sqt)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_res.valid <= 1'b0;
        end else begin
            r7_res.valid <= r6_c.valid;
        end
        r7_res.short_seg <= r6_c.short_seg;
        if (r6_c.trivial) begin
            r7_res.dsq <= r6_c.dist_s;
        end else if (r6_c.far) begin
            r7_res.dsq <= r6_c.dist_e;
        end else begin
            r7_res.dsq <= sat_dist(w_sum_p);
        end
    end

    assign o_res = r7_res;

endmodule
`default_nettype wire

// ===== hdl/sepr_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sepr_merge
// Two-level registered minimum over the four lane results and the cut test.
// ----------------------------------------------------------------------------
module sepr_merge (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sepr_pkg::t_lane_res         i_res [sepr_pkg::NUM_LANES],
    input  wire logic [sepr_pkg::REG_W-1:0]  i_max_dist,
    output logic                             o_valid,
    output sepr_pkg::t_out                   o_data
);
    import sepr_pkg::*;

    logic              r1_valid, r1_short;
    logic [DIST_W-1:0] r1_m01, r1_m23;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_res[0].valid;
        end
        r1_m01   <= (i_res[1].dsq < i_res[0].dsq) ? i_res[1].dsq : i_res[0].dsq;
        r1_m23   <= (i_res[3].dsq < i_res[2].dsq) ? i_res[3].dsq : i_res[2].dsq;
        r1_short <= i_res[0].short_seg | i_res[1].short_seg
                  | i_res[2].short_seg | i_res[3].short_seg;
    end

    logic [DIST_W-1:0] w_best;
    logic              r2_valid;
    t_out              r2_data;

    assign w_best = (r1_m23 < r1_m01) ? r1_m23 : r1_m01;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_data.compatible         <= w_best < i_max_dist;
        r2_data.min_dist_sq        <= w_best;
        r2_data.short_segment_seen <= r1_short;
    end

    assign o_valid = r2_valid;
    assign o_data  = r2_data;

endmodule
`default_nettype wire

// ===== hdl/sepr_ofifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sepr_ofifo
// Result buffer behind the free-running pipeline; holds every item in flight.
// ----------------------------------------------------------------------------
module sepr_ofifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sepr_pkg::t_out  i_data,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output sepr_pkg::t_out       o_data
);
    import sepr_pkg::*;

    t_out             r_mem [FIFO_DEPTH];
    logic [FIFO_AW:0] r_wr, r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr[FIFO_AW-1:0]] <= i_data;
        end
    end

    assign o_valid = r_wr != r_rd;
    assign o_data  = r_mem[r_rd[FIFO_AW-1:0]];

endmodule
`default_nettype wire

// ===== hdl/segment_endpoint_proximity_test_top.sv =====
// Path: from input transfer to result valid, an item passes through
//   3 difference/product stages, one divider stage per bit of t, 4 projection
//   stages, 2 merge stages and the result buffer.
// Throughput: one item per cycle; the input stalls once 32 items are in flight.
// Reset: synchronous, active low; clears pipeline valids, buffer and both
//   configuration registers.
`default_nettype none
// ----------------------------------------------------------------------------
// segment_endpoint_proximity_test_top
// Minimum endpoint-to-segment squared distance of two segments, four lanes.
// ----------------------------------------------------------------------------
module segment_endpoint_proximity_test_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire sepr_pkg::t_in               i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output sepr_pkg::t_out                   o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [sepr_pkg::REG_W-1:0]  i_cfg_data
);
    import sepr_pkg::*;

    logic [REG_W-1:0] r_max_dist, r_min_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= '0;
            r_min_len  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_DIST_SQ:   r_max_dist <= i_cfg_data;
                CFG_MIN_LENGTH_SQ: r_min_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // items accepted and not yet delivered
    logic [FIFO_AW:0] r_cnt;
    logic             w_acc, w_del;

    assign o_in_stall = r_cnt == (FIFO_AW+1)'(FIFO_DEPTH);
    assign w_acc      = i_in_valid & ~o_in_stall;
    assign w_del      = o_out_valid & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_acc && !w_del) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (!w_acc && w_del) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    t_pt a_s, a_e, b_s, b_e;
    assign a_s = '{w: i_in_data.a_start_w, t: i_in_data.a_start_t};
    assign a_e = '{w: i_in_data.a_end_w,   t: i_in_data.a_end_t};
    assign b_s = '{w: i_in_data.b_start_w, t: i_in_data.b_start_t};
    assign b_e = '{w: i_in_data.b_end_w,   t: i_in_data.b_end_t};

    t_lane_res w_res [NUM_LANES];

    sepr_lane u_lane0 (.i_clk, .i_rst_n, .i_valid(w_acc), .i_p(a_s), .i_s(b_s),
                       .i_e(b_e), .i_min_len(r_min_len), .o_res(w_res[0]));
    sepr_lane u_lane1 (.i_clk, .i_rst_n, .i_valid(w_acc), .i_p(a_e), .i_s(b_s),
                       .i_e(b_e), .i_min_len(r_min_len), .o_res(w_res[1]));
    sepr_lane u_lane2 (.i_clk, .i_rst_n, .i_valid(w_acc), .i_p(b_s), .i_s(a_s),
                       .i_e(a_e), .i_min_len(r_min_len), .o_res(w_res[2]));
    sepr_lane u_lane3 (.i_clk, .i_rst_n, .i_valid(w_acc), .i_p(b_e), .i_s(a_s),
                       .i_e(a_e), .i_min_len(r_min_len), .o_res(w_res[3]));

    logic w_mrg_valid;
    t_out w_mrg_data;

    sepr_merge u_merge (
        .i_clk, .i_rst_n,
        .i_res      (w_res),
        .i_max_dist (r_max_dist),
        .o_valid    (w_mrg_valid),
        .o_data     (w_mrg_data)
    );

    sepr_ofifo u_ofifo (
        .i_clk, .i_rst_n,
        .i_push  (w_mrg_valid),
        .i_data  (w_mrg_data),
        .i_pop   (w_del),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("in-flight count beyond buffer depth");

    a_out_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != '0)
        else $error("result presented with no item in flight");

    a_merge_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mrg_valid |-> r_cnt != '0)
        else $error("merge produced a result with no item in flight");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res[0].valid == w_res[3].valid)
        else $error("lane pipelines out of step");

endmodule
`default_nettype wire
